@@ rtl/ffha_pkg.sv @@
// Shared types and constants for the first-fit heap allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
package ffha_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned HEAP_WORD_BITS = 13;
  localparam int unsigned OFFSET_BITS    = 16;
  localparam int unsigned COUNT_BITS     = 16;
  localparam int unsigned NWORD_BITS     = 14;
  localparam int unsigned HDR_BITS       = 15;
  localparam int unsigned SIZE_BITS      = 14;
  localparam int unsigned STATUS_BITS    = 3;

  // Request limits in bytes and the smallest usable arena in words.
  localparam int unsigned MIN_REQUEST = 14;
  localparam int unsigned MAX_REQUEST = 32762;
  localparam int unsigned MIN_HEAP    = 8;

  // Configuration register indexes.
  localparam logic CFG_HEAP_WORDS   = 1'b0;
  localparam logic CFG_ARENA_OFFSET = 1'b1;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_NOMEM   = 3'd2,
    ST_CORRUPT = 3'd3,
    ST_NOHEAP  = 3'd4
  } status_t;

  // Link memory operations that the datapath can perform.
  typedef enum logic [3:0] {
    MEM_NONE     = 4'd0,
    MEM_RD_P     = 4'd1,
    MEM_RD_Q     = 4'd2,
    MEM_WR_MERGE = 4'd3,
    MEM_WR_SPLIT = 4'd4,
    MEM_WR_TAKE  = 4'd5,
    MEM_WR_FREE  = 4'd6,
    MEM_WR_L0    = 4'd7,
    MEM_WR_L1    = 4'd8,
    MEM_WR_L2    = 4'd9,
    MEM_WR_L3    = 4'd10
  } mem_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_in;
    logic    init_walk;
    logic    ld_ep;
    logic    ld_eq;
    logic    q_from_ep;
    logic    merge;
    logic    adv_p;
    logic    set_wrap;
    mem_op_t mem_op;
    logic    res_load;
    status_t res_status;
    logic    res_data;
    logic    res_size;
    logic    out_load;
  } ffha_cmd_t;

  // Status flags from the datapath to the controller.
  typedef struct packed {
    logic    relayout;
    logic    n_zero;
    action_t act;
    logic    cnt_zero;
    logic    cnt_big;
    logic    off_zero;
    logic    off_bad;
    logic    ep_busy;
    logic    q_bad;
    logic    eq_busy;
    logic    eq_next_bad;
    logic    fits;
    logic    split;
    logic    adv_fwd;
    logic    adv_over;
    logic    wrap_ok;
    logic    wrapped;
    logic    cur_hit;
    logic    walk_bad;
    logic    out_free;
  } ffha_sts_t;

endpackage

@@ rtl/ffha_ram.sv @@
// Generic single-port RAM with a registered read port.
// Holds the block link headers; no dependencies.
module ffha_ram #(
  parameter int unsigned WIDTH = 13,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One access per cycle: a write, or a read whose data shows up next cycle.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

@@ rtl/ffha_ctrl.sv @@
// Controller state machine of the heap allocator: sequences decode, the chain
// walks, the layout writes and result delivery. Depends on ffha_pkg.
module ffha_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ffha_pkg::ffha_sts_t sts,
  output ffha_pkg::ffha_cmd_t cmd
);
  import ffha_pkg::*;

  typedef enum logic [16:0] {
    S_IDLE   = 17'h00001,
    S_DECODE = 17'h00002,
    S_RDP    = 17'h00004,
    S_LDP    = 17'h00008,
    S_CHKP   = 17'h00010,
    S_MQ     = 17'h00020,
    S_LDQ    = 17'h00040,
    S_CHKQ   = 17'h00080,
    S_FIT    = 17'h00100,
    S_TAKE   = 17'h00200,
    S_ADV    = 17'h00400,
    S_WCHK   = 17'h00800,
    S_DONE   = 17'h01000,
    S_L0     = 17'h02000,
    S_L1     = 17'h04000,
    S_L2     = 17'h08000,
    S_L3     = 17'h10000
  } state_t;

  state_t state, state_next;

  // A size write in the same cycle takes precedence, so no beat is taken then.
  assign in_ready = (state == S_IDLE) && !sts.relayout;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.mem_op     = MEM_NONE;
    cmd.res_status = ST_OK;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load_in = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next   = S_DONE;
        cmd.res_load = 1'b1;
        case (sts.act)
          ACT_ALLOC: begin
            if (sts.n_zero) begin
              cmd.res_status = ST_NOHEAP;
            end else if (sts.cnt_zero) begin
              cmd.res_status = ST_ZERO;
            end else if (sts.cnt_big) begin
              cmd.res_status = ST_NOMEM;
            end else begin
              cmd.res_load  = 1'b0;
              cmd.init_walk = 1'b1;
              state_next    = S_RDP;
            end
          end
          ACT_FREE, ACT_QUERY: begin
            if (sts.off_zero) begin
              cmd.res_status = ST_OK;
            end else if (sts.n_zero) begin
              cmd.res_status = ST_NOHEAP;
            end else if (sts.off_bad) begin
              cmd.res_status = ST_CORRUPT;
            end else begin
              cmd.res_load  = 1'b0;
              cmd.init_walk = 1'b1;
              state_next    = S_RDP;
            end
          end
          default: begin
            cmd.res_status = ST_OK;
          end
        endcase
      end
      S_RDP: begin
        cmd.mem_op = MEM_RD_P;
        state_next = S_LDP;
      end
      S_LDP: begin
        cmd.ld_ep  = 1'b1;
        state_next = (sts.act == ACT_ALLOC) ? S_CHKP : S_WCHK;
      end
      // Allocation: a free block starts a merge run, a busy one is passed.
      S_CHKP: begin
        if (!sts.ep_busy) begin
          cmd.q_from_ep = 1'b1;
          state_next    = S_MQ;
        end else begin
          state_next = S_ADV;
        end
      end
      S_MQ: begin
        if (sts.q_bad) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_CORRUPT;
          state_next     = S_DONE;
        end else begin
          cmd.mem_op = MEM_RD_Q;
          state_next = S_LDQ;
        end
      end
      S_LDQ: begin
        cmd.ld_eq  = 1'b1;
        state_next = S_CHKQ;
      end
      S_CHKQ: begin
        if (sts.eq_busy) begin
          state_next = S_FIT;
        end else if (sts.eq_next_bad) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_CORRUPT;
          state_next     = S_DONE;
        end else begin
          cmd.mem_op = MEM_WR_MERGE;
          cmd.merge  = 1'b1;
          state_next = S_MQ;
        end
      end
      S_FIT: begin
        if (sts.fits) begin
          if (sts.split) begin
            cmd.mem_op = MEM_WR_SPLIT;
          end
          state_next = S_TAKE;
        end else begin
          state_next = S_ADV;
        end
      end
      S_TAKE: begin
        cmd.mem_op     = MEM_WR_TAKE;
        cmd.res_load   = 1'b1;
        cmd.res_status = ST_OK;
        cmd.res_data   = 1'b1;
        state_next     = S_DONE;
      end
      // Step to the next block; the wrap from the top block is allowed once.
      S_ADV: begin
        if (sts.adv_fwd) begin
          if (sts.adv_over) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_CORRUPT;
            state_next     = S_DONE;
          end else begin
            cmd.adv_p  = 1'b1;
            state_next = S_RDP;
          end
        end else if (!sts.wrap_ok) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_CORRUPT;
          state_next     = S_DONE;
        end else if (sts.wrapped) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_NOMEM;
          state_next     = S_DONE;
        end else begin
          cmd.adv_p    = 1'b1;
          cmd.set_wrap = 1'b1;
          state_next   = S_RDP;
        end
      end
      // Free and query: walk the chain until the header is found.
      S_WCHK: begin
        state_next = S_DONE;
        if (sts.cur_hit) begin
          cmd.res_load = 1'b1;
          if (!sts.ep_busy) begin
            cmd.res_status = ST_CORRUPT;
          end else if (sts.act == ACT_FREE) begin
            cmd.mem_op = MEM_WR_FREE;
          end else begin
            cmd.res_size = 1'b1;
          end
        end else if (sts.walk_bad) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_CORRUPT;
        end else begin
          cmd.adv_p  = 1'b1;
          state_next = S_RDP;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      // Heap layout: four header writes.
      S_L0: begin
        if (sts.n_zero) begin
          state_next = S_IDLE;
        end else begin
          cmd.mem_op = MEM_WR_L0;
          state_next = S_L1;
        end
      end
      S_L1: begin
        cmd.mem_op = MEM_WR_L1;
        state_next = S_L2;
      end
      S_L2: begin
        cmd.mem_op = MEM_WR_L2;
        state_next = S_L3;
      end
      S_L3: begin
        cmd.mem_op = MEM_WR_L3;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    // A write of the size register restarts the layout.
    if (sts.relayout) begin
      state_next = S_L0;
    end
  end

  // Only one item is in flight at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while an item is in flight");

  // A size write blocks input until the layout is written.
  a_layout_blocks: assert property (@(posedge clk) disable iff (rst)
    sts.relayout |=> !in_ready)
    else $error("input ready during heap layout");

  // A result is only loaded into a free output register.
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("result overwrote a waiting beat");

endmodule

@@ rtl/ffha_dp.sv @@
// Datapath of the heap allocator: configuration, walk registers, link memory
// and the result and output registers. Depends on ffha_pkg and ffha_ram.
module ffha_dp #(
  parameter int unsigned HEAP_WORDS = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic [1:0]          action,
  input  logic [15:0]         byte_count,
  input  logic [15:0]         block_offset,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [2:0]          status,
  output logic [15:0]         data_offset,
  output logic [13:0]         size_bytes,
  input  ffha_pkg::ffha_cmd_t cmd,
  output ffha_pkg::ffha_sts_t sts
);
  import ffha_pkg::*;

  localparam int unsigned IW = $clog2(HEAP_WORDS);
  localparam int unsigned NW = IW + 1;
  localparam int unsigned EW = IW + 1;
  localparam int unsigned SW = ((IW > NWORD_BITS) ? IW : NWORD_BITS) + 1;

  // Configuration registers.
  logic [HEAP_WORD_BITS-1:0] heap_words;
  logic [OFFSET_BITS-1:0]    arena_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_words   <= '0;
      arena_offset <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_HEAP_WORDS:   heap_words   <= cfg_data[HEAP_WORD_BITS-1:0];
        CFG_ARENA_OFFSET: arena_offset <= {cfg_data[15:1], 1'b0};
        default: ;
      endcase
    end
  end

  // Live arena size: capped at the memory depth, zero when too small.
  logic [31:0]   hw_wide, n_cap;
  logic [NW-1:0] n, top;

  always_comb begin
    hw_wide = 32'(heap_words);
    n_cap   = (hw_wide > 32'(HEAP_WORDS)) ? 32'(HEAP_WORDS) : hw_wide;
    n       = (n_cap < 32'(MIN_HEAP)) ? '0 : NW'(n_cap);
    top     = n - NW'(1);
  end

  // Latched input beat.
  logic [1:0]             act_r;
  logic [COUNT_BITS-1:0]  cnt_r;
  logic [OFFSET_BITS-1:0] off_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act_r <= action;
      cnt_r <= byte_count;
      off_r <= block_offset;
    end
  end

  // Request size in words, header included, and the header from the offset.
  logic [COUNT_BITS-1:0]  cnt_eff;
  logic [NWORD_BITS-1:0]  nw_calc;
  logic [OFFSET_BITS-1:0] rel;
  logic [HDR_BITS-1:0]    hdr_calc;

  always_comb begin
    cnt_eff  = (cnt_r < COUNT_BITS'(MIN_REQUEST)) ? COUNT_BITS'(MIN_REQUEST) : cnt_r;
    nw_calc  = NWORD_BITS'((17'(cnt_eff) + 17'd3) >> 1);
    rel      = off_r - arena_offset;
    hdr_calc = HDR_BITS'(rel[15:1] - 15'd1);
  end

  // Walk registers.
  logic [IW-1:0]         p, q;
  logic [EW-1:0]         ep, eq;
  logic                  wraps;
  logic [NWORD_BITS-1:0] nw;
  logic [HDR_BITS-1:0]   hdr;
  logic [EW-1:0]         rdata;
  logic [IW-1:0]         ep_next, eq_next;

  assign ep_next = ep[EW-1:1];
  assign eq_next = eq[EW-1:1];

  always_ff @(posedge clk) begin
    if (cmd.init_walk) begin
      p     <= '0;
      wraps <= 1'b0;
      nw    <= nw_calc;
      hdr   <= hdr_calc;
    end else begin
      if (cmd.adv_p) begin
        p <= ep_next;
      end
      if (cmd.set_wrap) begin
        wraps <= 1'b1;
      end
    end
    if (cmd.q_from_ep) begin
      q <= ep_next;
    end else if (cmd.merge) begin
      q <= eq_next;
    end
    if (cmd.ld_ep) begin
      ep <= rdata;
    end else if (cmd.merge) begin
      ep <= eq;
    end
    if (cmd.ld_eq) begin
      eq <= rdata;
    end
  end

  // Chain comparisons for the controller.
  logic [NW-1:0] pz, qz, epn, eqn;
  logic [SW-1:0] ap_sum;
  logic [IW-1:0] ap;

  always_comb begin
    pz     = NW'(p);
    qz     = NW'(q);
    epn    = NW'(ep_next);
    eqn    = NW'(eq_next);
    ap_sum = SW'(p) + SW'(nw);
    ap     = IW'(ap_sum);
  end

  always_comb begin
    sts.relayout    = cfg_write && (cfg_index == CFG_HEAP_WORDS);
    sts.n_zero      = (n == '0);
    sts.act         = action_t'(act_r);
    sts.cnt_zero    = (cnt_r == '0);
    sts.cnt_big     = (cnt_r > COUNT_BITS'(MAX_REQUEST));
    sts.off_zero    = (off_r == '0);
    sts.off_bad     = rel[0] || (rel[15:1] <= 15'd1);
    sts.ep_busy     = ep[0];
    sts.q_bad       = (qz <= pz) || (qz >= top);
    sts.eq_busy     = eq[0];
    sts.eq_next_bad = (eqn <= qz) || (eqn > top);
    sts.fits        = (SW'(q) >= ap_sum);
    sts.split       = (SW'(q) > ap_sum);
    sts.adv_fwd     = (epn > pz);
    sts.adv_over    = (epn > top);
    sts.wrap_ok     = (pz == top) && (epn == '0);
    sts.wrapped     = wraps;
    sts.cur_hit     = (HDR_BITS'(p) == hdr);
    sts.walk_bad    = (epn <= pz) || (epn >= n);
    sts.out_free    = !out_valid || out_ready;
  end

  // Link memory port selection.
  logic          mem_en, mem_we;
  logic [IW-1:0] mem_addr;
  logic [EW-1:0] mem_wdata;

  always_comb begin
    mem_en    = 1'b1;
    mem_we    = 1'b1;
    mem_addr  = '0;
    mem_wdata = '0;
    case (cmd.mem_op)
      MEM_RD_P: begin
        mem_we   = 1'b0;
        mem_addr = p;
      end
      MEM_RD_Q: begin
        mem_we   = 1'b0;
        mem_addr = q;
      end
      MEM_WR_MERGE: begin
        mem_addr  = p;
        mem_wdata = eq;
      end
      MEM_WR_SPLIT: begin
        mem_addr  = ap;
        mem_wdata = ep;
      end
      MEM_WR_TAKE: begin
        mem_addr  = p;
        mem_wdata = {ap, 1'b1};
      end
      MEM_WR_FREE: begin
        mem_addr  = p;
        mem_wdata = {ep_next, 1'b0};
      end
      MEM_WR_L0: begin
        mem_addr  = '0;
        mem_wdata = {IW'(1), 1'b1};
      end
      MEM_WR_L1: begin
        mem_addr  = IW'(1);
        mem_wdata = {IW'(n - NW'(2)), 1'b0};
      end
      MEM_WR_L2: begin
        mem_addr  = IW'(n - NW'(2));
        mem_wdata = {IW'(top), 1'b1};
      end
      MEM_WR_L3: begin
        mem_addr  = IW'(top);
        mem_wdata = {IW'(0), 1'b1};
      end
      default: begin
        mem_en = 1'b0;
        mem_we = 1'b0;
      end
    endcase
  end

  ffha_ram #(
    .WIDTH (EW),
    .DEPTH (HEAP_WORDS)
  ) u_link_ram (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (rdata)
  );

  // Result values: data offset of the taken block, span of the queried one.
  logic [OFFSET_BITS-1:0] data_calc;
  logic [15:0]            span_diff;
  logic [SIZE_BITS-1:0]   size_calc;

  always_comb begin
    data_calc = arena_offset + OFFSET_BITS'({(17'(p) + 17'd1), 1'b0});
    span_diff = 16'(ep_next) - 16'(p);
    size_calc = {span_diff[12:0], 1'b0};
  end

  logic [STATUS_BITS-1:0] res_status;
  logic [OFFSET_BITS-1:0] res_data;
  logic [SIZE_BITS-1:0]   res_size;

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_status <= cmd.res_status;
      res_data   <= cmd.res_data ? data_calc : '0;
      res_size   <= cmd.res_size ? size_calc : '0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status      <= res_status;
      data_offset <= res_data;
      size_bytes  <= res_size;
    end
  end

  // A data offset is only reported for a successful allocation.
  a_data_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (data_offset != '0)) |-> (status == ST_OK))
    else $error("data offset with a failing status");

  // A size is only reported for a successful query.
  a_size_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (size_bytes != '0)) |-> (status == ST_OK))
    else $error("size with a failing status");

  // Merges only happen while the block under the cursor is free.
  a_merge_free: assert property (@(posedge clk) disable iff (rst)
    cmd.merge |-> (!ep[0] && !eq[0]))
    else $error("merge of a busy block");

endmodule

@@ rtl/first_fit_heap_allocator_top.sv @@
// Top level of the first-fit heap allocator with coalescing.
// Joins ffha_ctrl and ffha_dp; depends on ffha_pkg.
//
// Usage: configure heap_words (index 0) and arena_offset (index 1) through
// the write port while the block is idle; a write of heap_words lays out a
// fresh heap, during which in_ready stays low. Each input beat
// (action, byte_count, block_offset) yields exactly one output beat (status,
// data_offset, size_bytes). One item is processed at a time.
// Results that need no chain walk finish at decode. Allocate reads each
// block header in turn, passes busy blocks, merges a free block with the
// free neighbors that follow it and checks the fit; the block that fits is
// split if larger and marked. Free and query walk the chain block by block
// up to the header. The link memory has a single port: one read or one
// write per cycle. After reset there is no heap (heap_words is zero), no
// layout runs and requests report no heap, but null offsets and no-action
// beats report OK. When out_ready is low a finished result waits in the
// output register and the block holds the next result until it is taken.
module first_fit_heap_allocator_top #(
  parameter int unsigned HEAP_WORDS = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [15:0] byte_count,
  input  logic [15:0] block_offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [15:0] data_offset,
  output logic [13:0] size_bytes
);
  import ffha_pkg::*;

  ffha_cmd_t cmd;
  ffha_sts_t sts;

  ffha_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ffha_dp #(
    .HEAP_WORDS (HEAP_WORDS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .action       (action),
    .byte_count   (byte_count),
    .block_offset (block_offset),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .status       (status),
    .data_offset  (data_offset),
    .size_bytes   (size_bytes),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule

@@ tb/tb_first_fit_heap_allocator_top.sv @@
// Self-checking testbench for the first-fit heap allocator top level.
// Holds its own model of the block chain and compares every output beat in order;
// depends on ffha_pkg and first_fit_heap_allocator_top.
module tb_first_fit_heap_allocator_top;
  import ffha_pkg::*;

  localparam int unsigned DEPTH       = 4096;
  localparam int unsigned STALL_LIMIT = 200000;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned HOLD_AFTER  = 300;

  typedef struct {
    status_t   st;
    bit [15:0] data;
    bit [13:0] size;
  } outcome_t;

  // Mirrors the link store and the registers; one expected beat per request.
  class alloc_scoreboard;
    bit [12:0]  chain_link [DEPTH];
    bit [12:0]  heap_words_reg;
    bit [15:0]  arena_base;
    outcome_t   pending_results[$];
    bit [15:0]  live_blocks[$];
    bit [15:0]  last_freed;
    int         bad_results;

    function int unsigned usable_words();
      int unsigned n;
      n = heap_words_reg;
      if (n > DEPTH) n = DEPTH;
      return (n < 8) ? 0 : n;
    endfunction

    // Start block, one free block, guard block and top block.
    function void lay_out_heap();
      int unsigned n;
      n = usable_words();
      if (n == 0) return;
      chain_link[0]     = 13'((1 << 1) | 1);
      chain_link[1]     = 13'((n - 2) << 1);
      chain_link[n - 2] = 13'(((n - 1) << 1) | 1);
      chain_link[n - 1] = 13'd1;
    endfunction

    function void write_reg(logic idx, bit [15:0] value);
      if (idx == CFG_HEAP_WORDS) begin
        heap_words_reg = value[12:0];
        lay_out_heap();
      end else begin
        arena_base = value & 16'hFFFE;
      end
      live_blocks.delete();
      last_freed = '0;
    endfunction

    // True when h is a busy header reached by walking the chain, start excluded.
    function bit is_live_header(int unsigned h, int unsigned n);
      int unsigned cur;
      int unsigned nx;
      cur = 0;
      for (int unsigned steps = 0; steps < n; steps++) begin
        if (cur == h) return (h != 0) && chain_link[cur][0];
        nx = chain_link[cur][12:1];
        if (nx <= cur || nx >= n) return 1'b0;
        cur = nx;
      end
      return 1'b0;
    endfunction

    // First-fit walk with merging of free neighbors and a split of the surplus.
    function status_t first_fit(int unsigned nw, int unsigned n, output int unsigned hdr);
      int unsigned top;
      int unsigned p;
      int unsigned q;
      int unsigned nq;
      int unsigned ap;
      int unsigned wraps;
      top = n - 1;
      p = 0;
      wraps = 0;
      hdr = 0;
      forever begin
        if (p >= n) return ST_CORRUPT;
        if (!chain_link[p][0]) begin
          forever begin
            q = chain_link[p][12:1];
            if (q <= p || q >= top) return ST_CORRUPT;
            if (chain_link[q][0]) break;
            nq = chain_link[q][12:1];
            if (nq <= q || nq > top) return ST_CORRUPT;
            chain_link[p] = chain_link[q];
          end
          if (q >= p + nw) begin
            ap = p + nw;
            if (q > ap) chain_link[ap] = chain_link[p];
            chain_link[p] = 13'((ap << 1) | 1);
            hdr = p;
            return ST_OK;
          end
        end
        q = p;
        p = chain_link[p][12:1];
        if (p > q) begin
          if (p > top) return ST_CORRUPT;
          continue;
        end
        if (q != top || p != 0) return ST_CORRUPT;
        wraps++;
        if (wraps > 1) return ST_NOMEM;
      end
    endfunction

    // Called for each accepted input beat; queues the result it must produce.
    function void note_request(action_t act, bit [15:0] cnt, bit [15:0] off);
      outcome_t    want;
      int unsigned n;
      int unsigned req;
      int unsigned hdr;
      bit [15:0]   rel;
      n = usable_words();
      want.st = ST_OK;
      want.data = '0;
      want.size = '0;
      hdr = 0;
      case (act)
        ACT_ALLOC: begin
          req = cnt;
          if (n == 0) begin
            want.st = ST_NOHEAP;
          end else if (req == 0) begin
            want.st = ST_ZERO;
          end else begin
            if (req < MIN_REQUEST) req = MIN_REQUEST;
            if (req > MAX_REQUEST) begin
              want.st = ST_NOMEM;
            end else begin
              want.st = first_fit((req + 3) >> 1, n, hdr);
              if (want.st == ST_OK) begin
                want.data = 16'(arena_base + ((hdr + 1) << 1));
                live_blocks.push_back(want.data);
              end
            end
          end
        end
        ACT_FREE, ACT_QUERY: begin
          if (off == 0) begin
            want.st = ST_OK;
          end else if (n == 0) begin
            want.st = ST_NOHEAP;
          end else begin
            rel = off - arena_base;
            if (rel[0] || rel[15:1] == 0 || !is_live_header(rel[15:1] - 1, n)) begin
              want.st = ST_CORRUPT;
            end else begin
              hdr = rel[15:1] - 1;
              if (act == ACT_FREE) begin
                chain_link[hdr][0] = 1'b0;
                last_freed = off;
                for (int i = 0; i < live_blocks.size(); i++) begin
                  if (live_blocks[i] == off) begin
                    live_blocks.delete(i);
                    break;
                  end
                end
              end else begin
                want.size = 14'((int'(chain_link[hdr][12:1]) - hdr) << 1);
              end
            end
          end
        end
        default: begin
        end
      endcase
      pending_results.push_back(want);
    endfunction

    // Called for each accepted output beat; compares it with the oldest expectation.
    function void check_result(logic [2:0] st, logic [15:0] data, logic [13:0] size);
      outcome_t want;
      if (pending_results.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("unexpected result beat: status %0d data %h size %0d", st, data, size);
        return;
      end
      want = pending_results.pop_front();
      if (st !== want.st || data !== want.data || size !== want.size) begin
        bad_results++;
        if (bad_results <= 10)
          $display("result mismatch: status exp %0d got %0d, data exp %h got %h, %s %0d got %0d",
                   want.st, st, want.data, data, "size exp", want.size, size);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  action_t     action = ACT_ALLOC;
  logic [15:0] byte_count = '0;
  logic [15:0] block_offset = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [15:0] data_offset;
  logic [13:0] size_bytes;

  alloc_scoreboard sb;
  int unsigned     items_sent = 0;
  int unsigned     idle_pct = 25;
  bit              calm = 1'b0;
  bit              long_hold_done = 1'b0;
  int unsigned     quiet_cycles = 0;

  first_fit_heap_allocator_top #(
    .HEAP_WORDS(DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .action(action),
    .byte_count(byte_count),
    .block_offset(block_offset),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .data_offset(data_offset),
    .size_bytes(size_bytes)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Output side: random ready runs and stall bursts, one long hold-off, none at the end.
  always begin
    int unsigned ready_run;
    int unsigned stall_run;
    ready_run = 0;
    stall_run = 0;
    forever begin
      @(negedge clk);
      if (calm) begin
        out_ready <= 1'b1;
      end else if (!long_hold_done && items_sent >= HOLD_AFTER) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        long_hold_done = 1'b1;
      end else if (ready_run > 0) begin
        out_ready <= 1'b1;
        ready_run--;
      end else if (stall_run > 0) begin
        out_ready <= 1'b0;
        stall_run--;
      end else begin
        out_ready <= 1'b1;
        ready_run = $urandom_range(1, 40);
        stall_run = $urandom_range(0, 1) ? $urandom_range(1, 8) : 0;
      end
    end
  end

  // Every accepted result beat goes to the scoreboard.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(status, data_offset, size_bytes);
  end

  // Ends the run when neither channel has moved a beat for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_first_fit_heap_allocator_top NOT OK");
        $finish;
      end
    end
  end

  // Offers one request beat, possibly after an idle burst, and waits for acceptance.
  task automatic send_item(action_t act, bit [15:0] cnt, bit [15:0] off);
    int unsigned gap;
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 8);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    action       <= act;
    byte_count   <= cnt;
    block_offset <= off;
    do @(posedge clk); while (!in_ready);
    sb.note_request(act, cnt, off);
    items_sent++;
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_for_drain();
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  // Rewrites both registers on an idle block; heap_words last so the layout follows it.
  task automatic configure(bit [15:0] words, bit [15:0] base);
    release_input();
    wait_for_drain();
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= CFG_ARENA_OFFSET;
    cfg_data  <= base;
    @(posedge clk);
    sb.write_reg(CFG_ARENA_OFFSET, base);
    @(negedge clk);
    cfg_index <= CFG_HEAP_WORDS;
    cfg_data  <= words;
    @(posedge clk);
    sb.write_reg(CFG_HEAP_WORDS, words);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Mostly allocate, free and query of live blocks; the rest is noise and misuse.
  task automatic random_phase(int unsigned count, int unsigned max_bytes);
    int unsigned r;
    int unsigned k;
    action_t     act;
    bit [15:0]   cnt;
    bit [15:0]   off;
    repeat (count) begin
      cnt = 16'($urandom);
      off = 16'($urandom);
      r = $urandom_range(0, 99);
      if (r < 45) begin
        act = ACT_ALLOC;
        cnt = 16'($urandom_range(1, max_bytes));
      end else if (r < 72 && sb.live_blocks.size() > 0) begin
        act = ACT_FREE;
        k = $urandom_range(0, sb.live_blocks.size() - 1);
        off = sb.live_blocks[k];
      end else if (r < 86 && sb.live_blocks.size() > 0) begin
        act = ACT_QUERY;
        k = $urandom_range(0, sb.live_blocks.size() - 1);
        off = sb.live_blocks[k];
      end else begin
        case ($urandom_range(0, 6))
          0: act = ACT_NONE;
          1: begin
            act = ACT_ALLOC;
            cnt = '0;
          end
          2: act = ACT_ALLOC;
          3: act = ACT_FREE;
          4: act = ACT_QUERY;
          5: begin
            act = $urandom_range(0, 1) ? ACT_FREE : ACT_QUERY;
            off = '0;
          end
          default: begin
            act = ACT_FREE;
            off = sb.last_freed;
          end
        endcase
      end
      send_item(act, cnt, off);
    end
  endtask

  initial begin
    bit [15:0] base;
    sb = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // No heap after reset; null offsets still succeed.
    send_item(ACT_ALLOC, 16'd0, 16'hFFFF);
    send_item(ACT_ALLOC, 16'd100, 16'd0);
    send_item(ACT_FREE, 16'hFFFF, 16'd0);
    send_item(ACT_QUERY, 16'd0, 16'h1234);
    send_item(ACT_NONE, 16'hFFFF, 16'hFFFF);

    // Small heap; the odd arena offset has its low bit dropped.
    configure(16'd64, 16'h0101);
    base = 16'h0100;
    send_item(ACT_ALLOC, 16'd1, 16'd0);
    send_item(ACT_ALLOC, 16'd0, 16'h5555);
    send_item(ACT_ALLOC, 16'hFFFF, 16'hAAAA);
    send_item(ACT_ALLOC, 16'd32763, 16'd0);
    send_item(ACT_ALLOC, 16'd32762, 16'd0);
    send_item(ACT_ALLOC, 16'd13, 16'd0);
    send_item(ACT_ALLOC, 16'd15, 16'd0);
    send_item(ACT_QUERY, 16'd0, base + 16'd4);
    send_item(ACT_QUERY, 16'd0, base);
    send_item(ACT_QUERY, 16'd0, base + 16'd2);
    send_item(ACT_QUERY, 16'd0, base + 16'd5);
    send_item(ACT_FREE, 16'd0, base + 16'd4);
    send_item(ACT_FREE, 16'd0, base + 16'd4);
    send_item(ACT_FREE, 16'd0, base + 16'h14);
    send_item(ACT_ALLOC, 16'd20, 16'd0);
    // Guard block: query it, free it, then let a search run into it.
    send_item(ACT_QUERY, 16'd0, base + 16'd126);
    send_item(ACT_FREE, 16'd0, base + 16'd126);
    send_item(ACT_ALLOC, 16'd90, 16'd0);
    // Top block links back to word 0, so its span wraps.
    send_item(ACT_QUERY, 16'd0, base + 16'd128);
    send_item(ACT_NONE, 16'($urandom), 16'($urandom));

    // Random phases over a range of arena sizes and offsets.
    configure(16'd8, 16'd0);
    random_phase(40, 64);
    configure(16'd10, 16'd65534);
    random_phase(80, 20);
    configure(16'd7, 16'h1234);
    random_phase(30, 100);
    configure(16'd248, 16'hFFF0);
    random_phase(150, 120);
    // Let every pending result come back before going on.
    release_input();
    wait_for_drain();
    random_phase(150, 120);
    configure(16'd96, 16'h8000);
    random_phase(250, 60);
    configure(16'd4096, 16'd0);
    random_phase(80, 4000);
    configure(16'd4095, 16'h5554);
    random_phase(60, 8000);
    configure(16'd0, 16'h00AA);
    random_phase(20, 50);
    calm = 1'b1;
    configure(16'd128, 16'h2000);
    random_phase(460, 80);

    release_input();
    wait_for_drain();
    repeat (20) @(posedge clk);
    if (sb.bad_results == 0) begin
      $display("tb_first_fit_heap_allocator_top OK");
    end else begin
      $display("tb_first_fit_heap_allocator_top NOT OK");
    end
    $finish;
  end

endmodule
